// ----- hw/rtl/ordered_array_list_defines.svh -----
// Assertion helpers for the ordered list block
`ifndef ORDERED_ARRAY_LIST_DEFINES_SVH
`define ORDERED_ARRAY_LIST_DEFINES_SVH

`define OAL_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`define OAL_ASSERT(lbl, prop, msg) \
  `OAL_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

// ----- hw/rtl/oal_pkg.sv -----
`default_nettype none

package oal_pkg;

  localparam int DepthDef    = 64;
  localparam int ElemWidthDef = 32;
  localparam int CapW        = 7;
  localparam logic [CapW-1:0] CapReset = 7'd64;

  typedef enum logic [2:0] {
    OP_INS_HEAD = 3'd0,
    OP_APPEND   = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_READ     = 3'd3,
    OP_WRITE    = 3'd4,
    OP_FIND     = 3'd5,
    OP_CLEAR    = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_RANGE   = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  typedef struct packed {
    status_e status;
    logic    empty;
  } oal_flags_t;

endpackage

`default_nettype wire

// ----- hw/rtl/oal_if.sv -----
`default_nettype none

interface oal_req_if #(
  parameter int IDX_W  = 6,
  parameter int ELEM_W = 32
);
  logic              valid;
  logic              ready;
  logic [2:0]        operation;
  logic [IDX_W-1:0]  index;
  logic [ELEM_W-1:0] element;

  modport source (output valid, operation, index, element, input ready);
  modport sink   (input valid, operation, index, element, output ready);
endinterface

interface oal_rsp_if #(
  parameter int IDX_W  = 6,
  parameter int ELEM_W = 32,
  parameter int CNT_W  = 7
);
  logic              valid;
  logic              ready;
  oal_pkg::status_e  status;
  logic [ELEM_W-1:0] element_out;
  logic [IDX_W-1:0]  found_index;
  logic [CNT_W-1:0]  count;
  logic              empty_res;

  modport source (output valid, status, element_out, found_index, count, empty_res,
                  input ready);
  modport sink   (input valid, status, element_out, found_index, count, empty_res,
                  output ready);
endinterface

interface oal_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [oal_pkg::CapW-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/oal_ram.sv -----
`default_nettype none

module oal_ram #(
  parameter int DEPTH  = oal_pkg::DepthDef,
  parameter int ELEM_W = oal_pkg::ElemWidthDef,
  localparam int AW    = $clog2(DEPTH)
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [AW-1:0]     waddr_i,
  input  wire logic [ELEM_W-1:0] wdata_i,
  input  wire logic              re_i,
  input  wire logic [AW-1:0]     raddr_i,
  output logic      [ELEM_W-1:0] rdata_o
);

  logic [ELEM_W-1:0] mem [DEPTH];
  logic [ELEM_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/oal_seq.sv -----
`default_nettype none
`include "ordered_array_list_defines.svh"

module oal_seq #(
  parameter int DEPTH  = oal_pkg::DepthDef,
  parameter int ELEM_W = oal_pkg::ElemWidthDef,
  localparam int AW    = $clog2(DEPTH),
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire oal_pkg::op_e             op_i,
  input  wire logic [AW-1:0]            idx_i,
  input  wire logic [ELEM_W-1:0]        elem_i,
  input  wire logic [oal_pkg::CapW-1:0] cap_i,
  output logic                          res_valid_o,
  input  wire logic                     res_ready_i,
  output oal_pkg::oal_flags_t           flags_o,
  output logic      [ELEM_W-1:0]        eout_o,
  output logic      [AW-1:0]            found_o,
  output logic      [CW-1:0]            cnt_o,
  output logic                          mem_we_o,
  output logic      [AW-1:0]            mem_waddr_o,
  output logic      [ELEM_W-1:0]        mem_wdata_o,
  output logic                          mem_re_o,
  output logic      [AW-1:0]            mem_raddr_o,
  input  wire logic [ELEM_W-1:0]        mem_rdata_i
);

  localparam int MW = (CW > oal_pkg::CapW) ? CW : oal_pkg::CapW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DOWN,
    S_FIND,
    S_READ,
    S_RESP
  } state_e;

  state_e              state_q, state_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [AW-1:0]       ptr_q, ptr_d;
  logic                last_q, last_d;
  logic                pend_q, pend_d;
  logic [AW-1:0]       pa_q, pa_d;
  logic [AW-1:0]       idx_q, idx_d;
  logic [ELEM_W-1:0]   elem_q, elem_d;
  logic [ELEM_W-1:0]   eout_q, eout_d;
  logic [AW-1:0]       found_q, found_d;
  oal_pkg::status_e    status_q, status_d;

  logic [MW-1:0]       cap_w;
  logic [CW-1:0]       cap_eff;
  logic                idx_ok;
  logic [AW-1:0]       last_pos;

  assign cap_w    = MW'(cap_i);
  assign cap_eff  = (cap_w > MW'(DEPTH)) ? CW'(DEPTH) : CW'(cap_w);
  assign idx_ok   = CW'(idx_i) < cnt_q;
  assign last_pos = AW'(cnt_q - CW'(1));

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    last_d      = last_q;
    pend_d      = 1'b0;
    pa_d        = pa_q;
    idx_d       = idx_q;
    elem_d      = elem_q;
    eout_d      = eout_q;
    found_d     = found_q;
    status_d    = status_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = '0;
    mem_wdata_o = elem_q;
    mem_re_o    = 1'b0;
    mem_raddr_o = ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          idx_d    = idx_i;
          elem_d   = elem_i;
          eout_d   = '0;
          found_d  = '0;
          status_d = oal_pkg::ST_OK;
          last_d   = 1'b0;
          state_d  = S_RESP;
          if (cap_eff == '0) begin
            unique case (op_i) inside
              oal_pkg::OP_INS_HEAD, oal_pkg::OP_APPEND, oal_pkg::OP_REMOVE,
              oal_pkg::OP_READ, oal_pkg::OP_WRITE, oal_pkg::OP_FIND,
              oal_pkg::OP_CLEAR: status_d = oal_pkg::ST_FULL;
              default:           status_d = oal_pkg::ST_OK;
            endcase
          end else begin
            unique case (op_i) inside
              oal_pkg::OP_INS_HEAD, oal_pkg::OP_APPEND: begin
                if (cnt_q >= cap_eff) begin
                  status_d = oal_pkg::ST_FULL;
                end else if (op_i == oal_pkg::OP_APPEND || cnt_q == '0) begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = AW'(cnt_q);
                  mem_wdata_o = elem_i;
                  cnt_d       = cnt_q + CW'(1);
                end else begin
                  ptr_d   = last_pos;
                  state_d = S_UP;
                end
              end
              oal_pkg::OP_REMOVE: begin
                if (!idx_ok) begin
                  status_d = oal_pkg::ST_RANGE;
                end else begin
                  ptr_d   = idx_i;
                  state_d = S_DOWN;
                end
              end
              oal_pkg::OP_READ: begin
                if (!idx_ok) begin
                  status_d = oal_pkg::ST_RANGE;
                end else begin
                  mem_re_o    = 1'b1;
                  mem_raddr_o = idx_i;
                  state_d     = S_READ;
                end
              end
              oal_pkg::OP_WRITE: begin
                if (!idx_ok) begin
                  status_d = oal_pkg::ST_RANGE;
                end else begin
                  mem_we_o    = 1'b1;
                  mem_waddr_o = idx_i;
                  mem_wdata_o = elem_i;
                end
              end
              oal_pkg::OP_FIND: begin
                if (cnt_q == '0) begin
                  status_d = oal_pkg::ST_MISSING;
                end else begin
                  ptr_d   = '0;
                  state_d = S_FIND;
                end
              end
              oal_pkg::OP_CLEAR: cnt_d = '0;
              default: ;
            endcase
          end
        end
      end
      S_UP: begin
        if (pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = pa_q + AW'(1);
          mem_wdata_o = mem_rdata_i;
        end
        if (!last_q) begin
          mem_re_o = 1'b1;
          pend_d   = 1'b1;
          pa_d     = ptr_q;
          if (ptr_q == '0) begin
            last_d = 1'b1;
          end else begin
            ptr_d = ptr_q - AW'(1);
          end
        end else if (!pend_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = '0;
          mem_wdata_o = elem_q;
          cnt_d       = cnt_q + CW'(1);
          state_d     = S_RESP;
        end
      end
      S_DOWN: begin
        if (pend_q) begin
          if (pa_q == idx_q) begin
            eout_d = mem_rdata_i;
          end else begin
            mem_we_o    = 1'b1;
            mem_waddr_o = pa_q - AW'(1);
            mem_wdata_o = mem_rdata_i;
          end
        end
        if (!last_q) begin
          mem_re_o = 1'b1;
          pend_d   = 1'b1;
          pa_d     = ptr_q;
          if (ptr_q == last_pos) begin
            last_d = 1'b1;
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end else if (!pend_q) begin
          cnt_d   = cnt_q - CW'(1);
          state_d = S_RESP;
        end
      end
      S_FIND: begin
        if (pend_q && mem_rdata_i == elem_q) begin
          found_d  = pa_q;
          status_d = oal_pkg::ST_OK;
          state_d  = S_RESP;
        end else if (!last_q) begin
          mem_re_o = 1'b1;
          pend_d   = 1'b1;
          pa_d     = ptr_q;
          if (ptr_q == last_pos) begin
            last_d = 1'b1;
          end else begin
            ptr_d = ptr_q + AW'(1);
          end
        end else if (!pend_q) begin
          status_d = oal_pkg::ST_MISSING;
          state_d  = S_RESP;
        end
      end
      S_READ: begin
        eout_d  = mem_rdata_i;
        state_d = S_RESP;
      end
      S_RESP: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      last_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      last_q  <= last_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q    <= ptr_d;
    pa_q     <= pa_d;
    idx_q    <= idx_d;
    elem_q   <= elem_d;
    eout_q   <= eout_d;
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign in_ready_o    = (state_q == S_IDLE);
  assign res_valid_o   = (state_q == S_RESP);
  assign flags_o.status = status_q;
  assign flags_o.empty  = (cnt_q == '0);
  assign eout_o        = eout_q;
  assign found_o       = found_q;
  assign cnt_o         = cnt_q;

  `OAL_ASSERT(a_cnt_bound, cnt_q <= CW'(DEPTH), "entry count beyond store depth")
  `OAL_ASSERT(a_idle_no_pend, state_q == S_IDLE |-> !pend_q, "read in flight while idle")
  `OAL_ASSERT(a_no_rw_clash, !(mem_we_o && mem_re_o && mem_waddr_o == mem_raddr_o), "read and write hit one entry")
  `OAL_ASSERT(a_accept_leaves_idle, in_valid_i && in_ready_o |=> state_q != S_IDLE, "accepted beat not processed")

endmodule

`default_nettype wire

// ----- hw/rtl/ordered_array_list.sv -----
// Ordered list of up to DEPTH elements held in one synchronous entry memory.
// Channels: req (sink) carries operation, index and element; rsp (source)
// carries status, element_out, found_index, count and empty_res, one beat
// per request; cfg (sink) writes the capacity register and is always ready.
// A request is taken only while the sequencer is idle. Head insert and
// remove shift the entries and find searches them one entry at a time
// on the single read port and single write port of the entry memory.
// The result sits in an output register, so the next request is accepted
// while an earlier result waits; if the receiver stalls, the sequencer holds
// its finished result and takes no requests until the output register frees.
// Reset empties the list and sets capacity to 64; memory contents are not
// cleared and no clearing pass is needed.
`default_nettype none

module ordered_array_list #(
  parameter int DEPTH  = oal_pkg::DepthDef,
  parameter int ELEM_W = oal_pkg::ElemWidthDef
) (
  input wire logic  clk_i,
  input wire logic  rst_ni,
  oal_req_if.sink   req,
  oal_rsp_if.source rsp,
  oal_cfg_if.sink   cfg
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [oal_pkg::CapW-1:0] cap_q;

  logic                res_valid;
  logic                slot_free;
  oal_pkg::oal_flags_t flags;
  logic [ELEM_W-1:0]   eout;
  logic [AW-1:0]       found;
  logic [CW-1:0]       cnt;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ELEM_W-1:0]   mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [ELEM_W-1:0]   mem_rdata;

  logic                out_valid_q;
  oal_pkg::oal_flags_t out_flags_q;
  logic [ELEM_W-1:0]   out_eout_q;
  logic [AW-1:0]       out_found_q;
  logic [CW-1:0]       out_cnt_q;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= oal_pkg::CapReset;
    end else if (cfg.valid) begin
      cap_q <= cfg.data;
    end
  end

  oal_ram #(
    .DEPTH  (DEPTH),
    .ELEM_W (ELEM_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  oal_seq #(
    .DEPTH  (DEPTH),
    .ELEM_W (ELEM_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req.valid),
    .in_ready_o  (req.ready),
    .op_i        (oal_pkg::op_e'(req.operation)),
    .idx_i       (req.index),
    .elem_i      (req.element),
    .cap_i       (cap_q),
    .res_valid_o (res_valid),
    .res_ready_i (slot_free),
    .flags_o     (flags),
    .eout_o      (eout),
    .found_o     (found),
    .cnt_o       (cnt),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  // output register: load when empty or drained this cycle
  assign slot_free = !out_valid_q || rsp.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (slot_free) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_free && res_valid) begin
      out_flags_q <= flags;
      out_eout_q  <= eout;
      out_found_q <= found;
      out_cnt_q   <= cnt;
    end
  end

  assign rsp.valid       = out_valid_q;
  assign rsp.status      = out_flags_q.status;
  assign rsp.empty_res   = out_flags_q.empty;
  assign rsp.element_out = out_eout_q;
  assign rsp.found_index = out_found_q;
  assign rsp.count       = out_cnt_q;

endmodule

`default_nettype wire

// ----- test/ordered_array_list_tb.sv -----
`timescale 1ns / 1ps

module ordered_array_list_tb;
  import oal_pkg::*;

  localparam int Depth = DepthDef;
  localparam logic [2:0] OpUnused = 3'd7;
  localparam int IdleLimit = 2000;
  localparam int DrainCycles = 80;
  localparam int NumPhases = 15;
  localparam int PhaseItems = 88;
  localparam int ModeGrow = 0;
  localparam int ModeShrink = 1;
  localparam int ModeMixed = 2;
  localparam int CapRandom = -1;

  // weights per op code: head, append, remove, read, write, find, clear, unused
  localparam int OpWeight [3][8] = '{
    '{35, 35, 6, 8, 6, 8, 1, 1},
    '{8, 8, 48, 12, 10, 12, 1, 1},
    '{18, 18, 20, 14, 12, 14, 3, 1}
  };
  localparam int CapPlan [NumPhases] = '{
    64, 64, 5, 5, 127, 0, 1, 2, 65, 65, CapRandom, CapRandom, CapRandom, CapRandom, 64
  };
  localparam int ModePlan [NumPhases] = '{
    ModeGrow, ModeMixed, ModeMixed, ModeShrink, ModeGrow, ModeMixed, ModeMixed, ModeMixed,
    ModeGrow, ModeShrink, ModeMixed, ModeGrow, ModeShrink, ModeMixed, ModeShrink
  };

  typedef struct {
    status_e     status;
    logic [31:0] element_out;
    logic [5:0]  found_index;
    logic [6:0]  count;
    logic        empty;
  } answer_t;

  class list_tracker;
    logic [31:0] store [Depth];
    int unsigned held;
    int unsigned capacity;
    answer_t     awaited [$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned status_hits [4];

    function new();
      held = 0;
      capacity = CapReset;
      mismatches = 0;
      checked = 0;
      foreach (status_hits[s]) status_hits[s] = 0;
    endfunction

    function void set_capacity(logic [6:0] value);
      capacity = value;
    endfunction

    function void note_request(logic [2:0] op, logic [5:0] idx, logic [31:0] elem);
      answer_t     a;
      int unsigned cap;
      int          i;
      cap = (capacity > Depth) ? Depth : capacity;
      a.status = ST_OK;
      a.element_out = '0;
      a.found_index = '0;
      if (cap == 0) begin
        if (op != OpUnused) a.status = ST_FULL;
      end else begin
        case (op)
          OP_INS_HEAD, OP_APPEND: begin
            if (held >= cap) begin
              a.status = ST_FULL;
            end else begin
              if (op == OP_INS_HEAD) begin
                for (i = held; i > 0; i--) store[i] = store[i-1];
                store[0] = elem;
              end else begin
                store[held] = elem;
              end
              held++;
            end
          end
          OP_REMOVE, OP_READ, OP_WRITE: begin
            if (idx >= held) begin
              a.status = ST_RANGE;
            end else if (op == OP_REMOVE) begin
              a.element_out = store[idx];
              for (i = idx; i + 1 < held; i++) store[i] = store[i+1];
              held--;
            end else if (op == OP_READ) begin
              a.element_out = store[idx];
            end else begin
              store[idx] = elem;
            end
          end
          OP_FIND: begin
            a.status = ST_MISSING;
            for (i = 0; i < held; i++) begin
              if (store[i] == elem) begin
                a.status = ST_OK;
                a.found_index = 6'(i);
                break;
              end
            end
          end
          OP_CLEAR: begin
            held = 0;
          end
          default: begin
          end
        endcase
      end
      a.count = 7'(held);
      a.empty = (held == 0);
      status_hits[a.status]++;
      awaited.push_back(a);
    endfunction

    function void check_result(answer_t got);
      answer_t want;
      if (awaited.size() == 0) begin
        if (mismatches < 10)
          $display("result beat with nothing awaited: status %0d element %h",
                   got.status, got.element_out);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      checked++;
      if (got.status !== want.status || got.element_out !== want.element_out ||
          got.found_index !== want.found_index || got.count !== want.count ||
          got.empty !== want.empty) begin
        if (mismatches < 10) begin
          $display("mismatch on answer %0d:", checked);
          $display("  expected status %0d element %h found %0d count %0d empty %0b",
                   want.status, want.element_out, want.found_index, want.count, want.empty);
          $display("  actual   status %0d element %h found %0d count %0d empty %0b",
                   got.status, got.element_out, got.found_index, got.count, got.empty);
        end
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  oal_req_if req_if ();
  oal_rsp_if rsp_if ();
  oal_cfg_if cfg_if ();

  ordered_array_list u_top (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req    (req_if.sink),
    .rsp    (rsp_if.source),
    .cfg    (cfg_if.sink)
  );

  list_tracker tracker;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          sent = 0;
  int          cap_writes = 0;
  logic [31:0] elem_pool [8];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin : monitor
    answer_t got;
    logic    moved;
    if (rst_n) begin
      moved = 1'b0;
      if (rsp_if.valid && rsp_if.ready) begin
        got.status = rsp_if.status;
        got.element_out = rsp_if.element_out;
        got.found_index = rsp_if.found_index;
        got.count = rsp_if.count;
        got.empty = rsp_if.empty_res;
        tracker.check_result(got);
        moved = 1'b1;
      end
      if (req_if.valid && req_if.ready) begin
        tracker.note_request(req_if.operation, req_if.index, req_if.element);
        moved = 1'b1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        tracker.set_capacity(cfg_if.data);
        moved = 1'b1;
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk);
    $display("no beat moved for %0d cycles", IdleLimit);
    $display("== FAIL ==");
    $finish;
  end

  // receiver stalls: the stall rate is redrawn at random from 0, 15 and 45 percent
  initial begin : receiver
    int stall_left;
    int stall_pct;
    int cycle;
    stall_left = 0;
    stall_pct = 0;
    cycle = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      cycle++;
      if (cycle % 256 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 15;
          default: stall_pct = 45;
        endcase
      end
      if (stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        stall_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall_left = $urandom_range(1, 8);
      end
    end
  end

  task automatic send_request(input logic [2:0] op, input logic [5:0] idx,
                              input logic [31:0] elem);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        req_if.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.index <= idx;
    req_if.element <= elem;
    do @(posedge clk); while (!req_if.ready);
    burst_left--;
    sent++;
    @(negedge clk);
  endtask

  // hold the request channel until every awaited answer has arrived
  task automatic drain_answers();
    req_if.valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (tracker.awaited.size() != 0);
  endtask

  task automatic write_capacity(input logic [6:0] value);
    drain_answers();
    repeat (2) @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= value;
    do @(posedge clk); while (!cfg_if.ready);
    cap_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [2:0] pick_op(input int mode);
    int r;
    int acc;
    r = $urandom_range(0, 99);
    acc = 0;
    for (int c = 0; c < 8; c++) begin
      acc += OpWeight[mode][c];
      if (r < acc) return 3'(c);
    end
    return OP_FIND;
  endfunction

  function automatic logic [31:0] pick_element();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return elem_pool[$urandom_range(0, 7)];
    if (r < 55) return ($urandom_range(0, 1) == 1) ? 32'hFFFF_FFFF : 32'h0;
    return $urandom;
  endfunction

  function automatic logic [5:0] pick_index();
    int unsigned held;
    held = tracker.held;
    if (held > 0 && $urandom_range(0, 9) > 1) return 6'($urandom_range(0, held - 1));
    if ($urandom_range(0, 1) == 1) return (held > 63) ? 6'd63 : 6'(held);
    return 6'($urandom_range(0, 63));
  endfunction

  task automatic run_phase(input int mode, input int items);
    int pause_at;
    pause_at = $urandom_range(10, items - 10);
    foreach (elem_pool[i]) elem_pool[i] = $urandom;
    for (int k = 0; k < items; k++) begin
      if (k == pause_at) drain_answers();
      send_request(pick_op(mode), pick_index(), pick_element());
    end
  endtask

  initial begin
    tracker = new();
    rst_n = 1'b0;
    req_if.valid = 1'b0;
    req_if.operation = '0;
    req_if.index = '0;
    req_if.element = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    send_request(OP_READ, 6'd0, 32'h0);
    send_request(OP_REMOVE, 6'd0, 32'h0);
    send_request(OP_WRITE, 6'd0, 32'hFFFF_FFFF);
    send_request(OP_FIND, 6'd0, 32'h0);
    send_request(OP_APPEND, 6'd0, 32'h0);
    send_request(OP_INS_HEAD, 6'd63, 32'hFFFF_FFFF);
    send_request(OP_APPEND, 6'd0, 32'hA5A5_A5A5);
    send_request(OP_READ, 6'd2, 32'h0);
    send_request(OP_WRITE, 6'd1, 32'h5A5A_5A5A);
    send_request(OP_FIND, 6'd0, 32'h5A5A_5A5A);
    send_request(OP_FIND, 6'd0, 32'h1234_5678);
    send_request(OP_REMOVE, 6'd0, 32'h0);
    send_request(OP_READ, 6'd63, 32'h0);
    send_request(OpUnused, 6'd0, 32'h0);
    send_request(OP_CLEAR, 6'd0, 32'h0);
    send_request(OP_READ, 6'd0, 32'h0);

    write_capacity(7'd0);
    send_request(OP_INS_HEAD, 6'd0, 32'h1);
    send_request(OP_CLEAR, 6'd0, 32'h0);
    send_request(OpUnused, 6'd0, 32'h0);

    write_capacity(7'd2);
    send_request(OP_APPEND, 6'd0, 32'h1);
    send_request(OP_INS_HEAD, 6'd0, 32'h2);
    send_request(OP_APPEND, 6'd0, 32'h3);
    send_request(OP_REMOVE, 6'd1, 32'h0);

    write_capacity(7'd1);
    send_request(OP_INS_HEAD, 6'd0, 32'h4);
    send_request(OP_FIND, 6'd0, 32'h2);

    for (int p = 0; p < NumPhases; p++) begin
      if (CapPlan[p] == CapRandom) write_capacity(7'($urandom_range(3, 63)));
      else write_capacity(7'(CapPlan[p]));
      run_phase(ModePlan[p], PhaseItems);
    end

    drain_answers();
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d requests over %0d capacity settings, compared %0d answers",
             sent, cap_writes, tracker.checked);
    $display("Answers: %0d ok, %0d full or disabled, %0d out of range, %0d not found",
             tracker.status_hits[ST_OK], tracker.status_hits[ST_FULL],
             tracker.status_hits[ST_RANGE], tracker.status_hits[ST_MISSING]);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d answers never arrived",
               tracker.mismatches, tracker.awaited.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/oal_pkg.sv
hw/rtl/oal_if.sv
hw/rtl/oal_ram.sv
hw/rtl/oal_seq.sv
hw/rtl/ordered_array_list.sv
test/ordered_array_list_tb.sv
